FILE: sv/wsd_pkg.sv
// Shared types and constants for the WebSocket receive deframer.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HANDSHAKE = 3'd0,
      PH_SKIP      = 3'd1,
      PH_LEN7      = 3'd2,
      PH_EXTLEN    = 3'd3,
      PH_KEY       = 3'd4,
      PH_DATA      = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      LS_NONE  = 2'd0,
      LS_TWO   = 2'd1,
      LS_EIGHT = 2'd2
   } len_size_type;

   // 7-bit length escape code for the two-byte extended length and handshake terminator bytes
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_LF    = 8'h0a;

   // Extended length and mask key byte counts
   localparam logic [3:0] EXT16_BYTES     = 4'd2;
   localparam logic [3:0] EXT64_BYTES     = 4'd8;
   localparam logic [3:0] EXT64_LOW_START = 4'd4;
   localparam logic [3:0] KEY_BYTES       = 4'd4;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_present;
      logic       frame_last;
      logic       handshake_done;
   } rsp_type;

endpackage

FILE: sv/wsd_parser.sv
// Frame parser: connection state registers and per-byte next-state logic.
module wsd_parser
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] rx_byte,
   input  logic       restart,
   output logic       res_valid,
   output rsp_type    res
);

   phase_type              phase_ff, phase_in;
   logic [1:0]             term_ff, term_in;
   logic [3:0]             hc_ff, hc_in;
   len_size_type           ls_ff, ls_in;
   logic                   masked_ff, masked_in;
   logic [31:0]            key_ff, key_in;
   logic [LENGTH_BITS-1:0] rl_ff, rl_in;
   logic [1:0]             mi_ff, mi_in;
   logic                   hdr_done;
   logic [7:0]             key_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HANDSHAKE;
         term_ff   <= 2'd0;
         hc_ff     <= 4'd0;
         ls_ff     <= LS_NONE;
         masked_ff <= 1'b0;
         key_ff    <= 32'd0;
         rl_ff     <= '0;
         mi_ff     <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         term_ff   <= term_in;
         hc_ff     <= hc_in;
         ls_ff     <= ls_in;
         masked_ff <= masked_in;
         key_ff    <= key_in;
         rl_ff     <= rl_in;
         mi_ff     <= mi_in;
      end
   end

   always_comb begin
      case (mi_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      term_in   = term_ff;
      hc_in     = hc_ff;
      ls_in     = ls_ff;
      masked_in = masked_ff;
      key_in    = key_ff;
      rl_in     = rl_ff;
      mi_in     = mi_ff;
      hdr_done  = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      if (fire) begin
         if (restart) begin
            phase_in  = PH_HANDSHAKE;
            term_in   = 2'd0;
            hc_in     = 4'd0;
            ls_in     = LS_NONE;
            masked_in = 1'b0;
            key_in    = 32'd0;
            rl_in     = '0;
            mi_in     = 2'd0;
         end else begin
            unique case (phase_ff)
               PH_SKIP: begin
                  phase_in = PH_LEN7;
               end
               PH_LEN7: begin
                  masked_in = rx_byte[7];
                  hc_in     = 4'd0;
                  if (rx_byte[6:0] < LEN7_EXT16) begin
                     ls_in    = LS_NONE;
                     rl_in    = LENGTH_BITS'(rx_byte[6:0]);
                     hdr_done = 1'b1;
                  end else begin
                     rl_in    = '0;
                     ls_in    = (rx_byte[6:0] == LEN7_EXT16) ? LS_TWO : LS_EIGHT;
                     phase_in = PH_EXTLEN;
                  end
               end
               PH_EXTLEN: begin
                  // 64-bit length: only the low four bytes shift in
                  if (ls_ff == LS_TWO || hc_ff >= EXT64_LOW_START) begin
                     rl_in = {rl_ff[LENGTH_BITS-9:0], rx_byte};
                  end
                  hc_in = hc_ff + 4'd1;
                  if (hc_in >= ((ls_ff == LS_TWO) ? EXT16_BYTES : EXT64_BYTES)) begin
                     hdr_done = 1'b1;
                  end
               end
               PH_KEY: begin
                  key_in = {key_ff[23:0], rx_byte};
                  hc_in  = hc_ff + 4'd1;
                  if (hc_in >= KEY_BYTES) begin
                     hc_in = 4'd0;
                     mi_in = 2'd0;
                     if (rl_ff == '0) begin
                        phase_in       = PH_SKIP;
                        res_valid      = 1'b1;
                        res.frame_last = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  mi_in            = mi_ff + 2'd1;
                  rl_in            = rl_ff - LENGTH_BITS'(1);
                  res_valid        = 1'b1;
                  res.payload_byte = rx_byte ^ (masked_ff ? key_byte : 8'd0);
                  res.byte_present = 1'b1;
                  if (rl_in == '0) begin
                     phase_in       = PH_SKIP;
                     res.frame_last = 1'b1;
                  end
               end
               default: begin
                  // handshake wait: match CR LF CR LF anywhere in the stream
                  phase_in = PH_HANDSHAKE;
                  if (rx_byte == BYTE_CR) begin
                     term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
                  end else if (rx_byte == BYTE_LF) begin
                     if (term_ff == 2'd3) begin
                        term_in            = 2'd0;
                        phase_in           = PH_SKIP;
                        res_valid          = 1'b1;
                        res.handshake_done = 1'b1;
                     end else begin
                        term_in = (term_ff == 2'd1) ? 2'd2 : 2'd0;
                     end
                  end else begin
                     term_in = 2'd0;
                  end
               end
            endcase
            // header complete: mask key next, payload, or empty-frame marker
            if (hdr_done) begin
               hc_in = 4'd0;
               if (masked_in) begin
                  phase_in = PH_KEY;
               end else begin
                  mi_in = 2'd0;
                  if (rl_in == '0) begin
                     phase_in       = PH_SKIP;
                     res_valid      = 1'b1;
                     res.frame_last = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
         end
      end
   end

   a_byte_only_in_data: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.byte_present |-> phase_ff == PH_DATA)
      else $error("payload byte emitted outside payload phase");

   a_hs_then_skip: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.handshake_done |=> phase_ff == PH_SKIP)
      else $error("handshake marker not followed by frame header");

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.byte_present |-> res.payload_byte == 8'd0
                                         && (res.frame_last != res.handshake_done))
      else $error("malformed marker transaction");

endmodule

FILE: sv/wsd_outq.sv
// Two-entry result queue: output register plus skid register.
module wsd_outq
   import wsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop       = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push into full result queue");

endmodule

FILE: sv/websocket_frame_deframer_top.sv
// Top level of the WebSocket receive deframer: input register, parser, result queue.
// Each byte is held in the input register, parsed, and its result registered in the
// result queue's output register; a full queue holds the byte in the input register.
// Throughput: one byte per cycle, sustained while the result side keeps up.
// The input register and the two-entry result queue decouple the channels.
// Reset (synchronous, active high) returns to handshake wait and empties all stages.
// A restart byte clears the connection state the same way, without a result.
module websocket_frame_deframer_top
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   // received byte stream
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_restart,
   // unmasked payload and markers
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_present,
   output logic       rsp_frame_last,
   output logic       rsp_handshake_done
);

   // Input register: one byte waiting for the parser
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_restart_ff, in_restart_in;

   logic    q_full;
   logic    fire;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   // The parser consumes the held byte whenever the queue has a free slot; a
   // full queue only arises after the result side has stalled.
   assign fire      = in_valid_ff && !q_full;
   assign req_stall = in_valid_ff && q_full;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_restart_in = in_restart_ff;
      if (!req_stall) begin
         in_valid_in   = req_valid;
         in_byte_in    = req_rx_byte;
         in_restart_in = req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      in_restart_ff <= in_restart_in;
   end

   // Per-byte frame parsing against the connection state
   wsd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (in_byte_ff),
      .restart   (in_restart_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register with skid slot
   wsd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_byte_present   = out_data.byte_present;
   assign rsp_frame_last     = out_data.frame_last;
   assign rsp_handshake_done = out_data.handshake_done;

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid)
      else $error("input stalled with nothing pending downstream");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_restart_ff))
      else $error("held input transaction changed while stalled");

endmodule

FILE: tb/tb_websocket_frame_deframer_top.sv
// Testbench for the WebSocket receive deframer: byte streams against a scoreboard predictor.
module tb_websocket_frame_deframer_top
   import wsd_pkg::*;
();

   localparam int LENGTH_BITS = 32;
   // 7-bit length escape for the eight-byte extended length
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   // harmless filler byte, breaks a partial terminator in handshake junk
   localparam logic [7:0] BYTE_FILL = 8'h20;
   // receiver hold-off long enough to fill the input register and result queue
   localparam int HOLD_CYCLES = 60;
   // drain wait at the end to catch stray results
   localparam int DRAIN_CYCLES = 8;

   // Predictor of the deframer plus the store of expected result transactions.
   class deframer_scoreboard;
      phase_type phase;
      logic [1:0] crlf_seen;
      logic [3:0] hdr_count;
      len_size_type len_size;
      logic masked;
      logic [31:0] mask_key;
      logic [LENGTH_BITS-1:0] remaining;
      logic [1:0] key_idx;
      rsp_type pending[$];
      int errors;

      function new();
         errors = 0;
         restart_parse();
      endfunction

      function void restart_parse();
         phase = PH_HANDSHAKE;
         crlf_seen = '0;
         hdr_count = '0;
         len_size = LS_NONE;
         masked = 1'b0;
         mask_key = '0;
         remaining = '0;
         key_idx = '0;
      endfunction

      // Header and any mask key taken; returns 1 when an empty frame ends here.
      function logic open_payload();
         hdr_count = '0;
         key_idx = '0;
         if (remaining == '0) begin
            phase = PH_SKIP;
            return 1'b1;
         end
         phase = PH_DATA;
         return 1'b0;
      endfunction

      function logic end_header();
         if (masked) begin
            hdr_count = '0;
            phase = PH_KEY;
            return 1'b0;
         end
         return open_payload();
      endfunction

      // Called for every accepted input transaction.
      function void note_byte(logic [7:0] b, logic restart);
         rsp_type r;
         logic emit;
         logic [7:0] key;
         r = '0;
         emit = 1'b0;
         if (restart) begin
            restart_parse();
            return;
         end
         case (phase)
            PH_SKIP: phase = PH_LEN7;
            PH_LEN7: begin
               masked = b[7];
               hdr_count = '0;
               remaining = '0;
               if (b[6:0] < LEN7_EXT16) begin
                  len_size = LS_NONE;
                  remaining = LENGTH_BITS'(b[6:0]);
                  emit = end_header();
                  r.frame_last = emit;
               end else begin
                  len_size = (b[6:0] == LEN7_EXT16) ? LS_TWO : LS_EIGHT;
                  phase = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               // only the low four bytes of an eight-byte length count
               if (len_size == LS_TWO || hdr_count >= EXT64_LOW_START)
                  remaining = (remaining << 8) | LENGTH_BITS'(b);
               hdr_count = hdr_count + 4'd1;
               if (hdr_count >= ((len_size == LS_TWO) ? EXT16_BYTES : EXT64_BYTES)) begin
                  emit = end_header();
                  r.frame_last = emit;
               end
            end
            PH_KEY: begin
               mask_key = {mask_key[23:0], b};
               hdr_count = hdr_count + 4'd1;
               if (hdr_count >= KEY_BYTES) begin
                  emit = open_payload();
                  r.frame_last = emit;
               end
            end
            PH_DATA: begin
               key = masked ? mask_key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
               key_idx = key_idx + 2'd1;
               remaining = remaining - 1'b1;
               r.payload_byte = b ^ key;
               r.byte_present = 1'b1;
               r.frame_last = (remaining == '0);
               if (r.frame_last)
                  phase = PH_SKIP;
               emit = 1'b1;
            end
            default: begin
               phase = PH_HANDSHAKE;
               if (b == BYTE_CR) begin
                  crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
               end else if (b == BYTE_LF) begin
                  if (crlf_seen == 2'd3) begin
                     crlf_seen = '0;
                     phase = PH_SKIP;
                     r.handshake_done = 1'b1;
                     emit = 1'b1;
                  end else begin
                     crlf_seen = (crlf_seen == 2'd1) ? 2'd2 : 2'd0;
                  end
               end else begin
                  crlf_seen = '0;
               end
            end
         endcase
         if (emit)
            pending = {pending, r};
      endfunction

      // Called for every accepted result transaction.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: payload_byte %02h byte_present %0b frame_last %0b hs %0b",
                   got.payload_byte, got.byte_present, got.frame_last, got.handshake_done);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.payload_byte != want.payload_byte) begin
            $error("payload_byte: expected %02h, got %02h", want.payload_byte, got.payload_byte);
            errors++;
         end
         if (got.byte_present != want.byte_present) begin
            $error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
            errors++;
         end
         if (got.frame_last != want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
            errors++;
         end
         if (got.handshake_done != want.handshake_done) begin
            $error("handshake_done: expected %0b, got %0b", want.handshake_done,
                   got.handshake_done);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_rx_byte;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_payload_byte;
   logic rsp_byte_present;
   logic rsp_frame_last;
   logic rsp_handshake_done;

   deframer_scoreboard sb;
   int sent_count = 0;
   // sender idle chance per cycle, in percent (stimulus process only)
   int snd_idle_pct = 0;
   // receiver stall chance per cycle; written with nonblocking assignments
   int rsp_idle_pct = 0;
   // bumped by the stimulus to ask the receiver for one long hold-off
   int hold_seq = 0;

   websocket_frame_deframer_top #(
      .LENGTH_BITS(LENGTH_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_present(rsp_byte_present),
      .rsp_frame_last(rsp_frame_last),
      .rsp_handshake_done(rsp_handshake_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both channels are observed at the rising edge. Inputs change by nonblocking
   // assignment and the block's outputs only move after the edge, so the values
   // read here are the ones the edge acted on. The input is noted before the result is
   // checked; results trail their bytes through the input and output registers anyway.
   always @(posedge clock) begin : monitor
      rsp_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_byte(req_rx_byte, req_restart);
         if (rsp_valid && !rsp_stall) begin
            got.payload_byte = rsp_payload_byte;
            got.byte_present = rsp_byte_present;
            got.frame_last = rsp_frame_last;
            got.handshake_done = rsp_handshake_done;
            sb.check_result(got);
         end
      end
   end

   // Result side: random stalls at the current rate, plus a long hold-off on
   // request, counted here so that the sender keeps offering bytes meanwhile.
   initial begin : receiver
      int hold_left;
      int hold_seen;
      rsp_stall = 1'b0;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // One input transaction. Idle cycles come first, at the sender's rate. The
   // stall is looked at on the falling edge, where it is settled for the next
   // rising edge; the task returns on the edge that accepts the byte.
   task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_restart <= rs;
      do
         @(negedge clock);
      while (req_stall);
      @(posedge clock);
      sent_count++;
   endtask

   // Sender pause: nothing offered until every expected result has come.
   task automatic wait_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0)
         @(posedge clock);
   endtask

   // Junk with partial terminators, then CR LF CR LF. Junk never completes the
   // terminator itself, so frame parsing starts right after the final LF.
   task automatic send_handshake();
      logic [1:0] seen;
      logic [7:0] b;
      seen = '0;
      repeat ($urandom_range(10)) begin
         case ($urandom_range(3))
            0: b = BYTE_CR;
            1: b = BYTE_LF;
            default: b = rand_byte();
         endcase
         if (seen == 2'd3 && b == BYTE_LF)
            b = BYTE_CR;
         if (b == BYTE_CR)
            seen = (seen == 2'd2) ? 2'd3 : 2'd1;
         else if (b == BYTE_LF)
            seen = (seen == 2'd1) ? 2'd2 : 2'd0;
         else
            seen = '0;
         send_byte(b);
      end
      // a trailing CR LF would let the first half of the terminator finish it
      if (seen == 2'd2)
         send_byte(BYTE_FILL);
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
   endtask

   // Frame with random first byte, key and payload; data_bytes below len cuts it short.
   task automatic send_frame(input logic [31:0] len, input len_size_type ext,
                             input logic masked, input int unsigned data_bytes);
      logic [6:0] len7;
      int i;
      send_byte(rand_byte());
      if (ext == LS_NONE)
         len7 = len[6:0];
      else if (ext == LS_TWO)
         len7 = LEN7_EXT16;
      else
         len7 = LEN7_EXT64;
      send_byte({masked, len7});
      if (ext == LS_TWO) begin
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end
      if (ext == LS_EIGHT) begin
         // upper half of the 64-bit length is ignored by the block
         repeat (4) send_byte(rand_byte());
         for (i = 3; i >= 0; i--)
            send_byte(len[8 * i +: 8]);
      end
      if (masked)
         repeat (4) send_byte(rand_byte());
      repeat (data_bytes) send_byte(rand_byte());
   endtask

   // Well-formed frame, mostly short payloads, now and then a longer one.
   task automatic send_random_frame();
      int unsigned pick;
      logic [31:0] len;
      len_size_type ext;
      pick = $urandom_range(99);
      if (pick < 55) begin
         ext = LS_NONE;
         len = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12);
      end else if (pick < 80) begin
         ext = LS_TWO;
         len = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(20);
      end else begin
         ext = LS_EIGHT;
         len = $urandom_range(20);
      end
      send_frame(len, ext, 1'($urandom_range(1)), len);
   endtask

   // Frame announcing a random, mostly large length, cut off by a restart and a fresh handshake.
   task automatic send_cut_frame();
      logic [31:0] len;
      len_size_type ext;
      ext = ($urandom_range(1) == 0) ? LS_TWO : LS_EIGHT;
      len = (ext == LS_TWO) ? {16'h0000, 16'($urandom())} : $urandom();
      send_frame(len, ext, 1'($urandom_range(1)), $urandom_range(6));
      send_byte(rand_byte(), 1'b1);
      send_handshake();
   endtask

   // Raw random bytes with stray restarts, then resynchronise.
   task automatic send_noise();
      repeat ($urandom_range(1, 12)) send_byte(rand_byte(), $urandom_range(15) == 0);
      send_byte(rand_byte(), 1'b1);
      send_handshake();
   endtask

   task automatic run_phase(input int snd_pct, input int rsp_pct, input int target);
      int unsigned stop_at;
      int unsigned pick;
      snd_idle_pct = snd_pct;
      rsp_idle_pct <= rsp_pct;
      // long receiver hold-off at the start while bytes keep coming
      hold_seq <= hold_seq + 1;
      stop_at = sent_count + target;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_random_frame();
         end else if (pick < 86) begin
            send_byte(rand_byte(), 1'b1);
            send_handshake();
         end else if (pick < 93) begin
            send_cut_frame();
         end else if (pick < 97) begin
            send_noise();
         end else begin
            wait_results();
         end
      end
      wait_results();
   endtask

   initial begin : stimulus
      logic [7:0] directed[$];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      req_restart = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: a restart while waiting; terminator after a false start;
      // empty unmasked control frame; masked two-byte payload; 126 escape with
      // length 1 and an all-ones byte; 127 escape with ignored high bytes, masked
      // and empty, so the end marker follows the key.
      directed = '{BYTE_CR, BYTE_CR, BYTE_LF, BYTE_CR, BYTE_LF,
                   8'h89, 8'h00,
                   8'h82, 8'h82, 8'h01, 8'h02, 8'h03, 8'h04, 8'hff, 8'h00,
                   8'h01, 8'h7e, 8'h00, 8'h01, 8'hff,
                   8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'hde, 8'had, 8'hbe, 8'hef};
      send_byte(rand_byte(), 1'b1);
      foreach (directed[i])
         send_byte(directed[i]);
      wait_results();

      run_phase(26, 78, 550);
      run_phase(78, 26, 550);
      run_phase(0, 0, 550);

      // catch any result that should not have been produced
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog for a stuck handshake or a lost result.
   initial begin : watchdog
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: websocket_frame_deframer_top.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/wsd_outq.sv
sv/websocket_frame_deframer_top.sv
tb/tb_websocket_frame_deframer_top.sv
